>>> rtl/cbf_pkg.sv
// shared types, constants and helpers for the velocity safety filter
`default_nettype none
package cbf_pkg;

    localparam int W_IN        = 32;
    localparam int W_D         = 33;
    localparam int W_CFG       = 31;
    localparam int W_S         = 67;
    localparam int W_MA        = 104;
    localparam int W_MB        = 36;
    localparam int W_ACC       = 136;
    localparam int DIGIT_W     = 4;
    localparam int MUL_DIGITS  = W_MB / DIGIT_W;
    localparam int DIV_BITS    = 35;
    localparam int SCALE_SH    = 17;
    localparam int W_SUM       = DIV_BITS + 2;
    localparam int FIFO_DEPTH  = 2;
    localparam logic [W_CFG-1:0] CFG_RESET = 31'd19661;

    typedef enum logic [0:0] {
        REG_SAFE_DIST = 1'b0,
        REG_CBF_GAMMA = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_WAIT,
        BK_CHECK,
        BK_DIV,
        BK_OUT
    } bk_state_t;

    typedef enum logic [2:0] {
        STEP_DXX,
        STEP_DYY,
        STEP_SAFE,
        STEP_GAMMA,
        STEP_DXU,
        STEP_DYU,
        STEP_NUMX,
        STEP_NUMY
    } step_t;

    typedef struct packed {
        logic signed [W_IN-1:0] ux;
        logic signed [W_IN-1:0] uy;
        logic signed [W_D-1:0]  dx;
        logic signed [W_D-1:0]  dy;
        logic                   d_zero;
    } item_t;

    typedef struct packed {
        logic                   start;
        logic                   neg;
        logic signed [W_MA-1:0] a;
        logic [W_MB-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [W_ACC-1:0] p;
    } mul_rsp_t;

    localparam logic signed [W_SUM-1:0] SUM_MAX = 37'sd2147483647;
    localparam logic signed [W_SUM-1:0] SUM_MIN = -37'sd2147483648;

    function automatic logic signed [W_IN-1:0] sat32(input logic signed [W_SUM-1:0] v);
        logic signed [W_IN-1:0] r;
        if (v > SUM_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SUM_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[W_IN-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cbf_front.sv
// input side: accepts requests, forms the offset vector and flags coincident points
`default_nettype none
module cbf_front (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [191:0]         s_tdata,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cbf_pkg::item_t            q_item
);

    logic signed [cbf_pkg::W_D-1:0] dx;
    logic signed [cbf_pkg::W_D-1:0] dy;

    always_comb begin
        dx = cbf_pkg::W_D'($signed(s_tdata[95:64])) - cbf_pkg::W_D'($signed(s_tdata[159:128]));
        dy = cbf_pkg::W_D'($signed(s_tdata[127:96])) - cbf_pkg::W_D'($signed(s_tdata[191:160]));
        q_item.ux     = $signed(s_tdata[31:0]);
        q_item.uy     = $signed(s_tdata[63:32]);
        q_item.dx     = dx;
        q_item.dy     = dy;
        q_item.d_zero = (dx == '0) && (dy == '0);
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule
`default_nettype wire

>>> rtl/cbf_fifo.sv
// two-entry request queue between front and back
`default_nettype none
module cbf_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire cbf_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output cbf_pkg::item_t      pop_item
);

    cbf_pkg::item_t entry_reg [cbf_pkg::FIFO_DEPTH];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full     = (count_reg == 2'(cbf_pkg::FIFO_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

endmodule
`default_nettype wire

>>> rtl/cbf_mul.sv
// shared radix-16 shift-add multiplier, signed multiplicand times magnitude
`default_nettype none
module cbf_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cbf_pkg::mul_req_t req,
    output cbf_pkg::mul_rsp_t      rsp
);

    logic signed [cbf_pkg::W_MA-1:0]  a_reg;
    logic [cbf_pkg::W_MB-1:0]         b_reg;
    logic signed [cbf_pkg::W_ACC-1:0] acc_reg;
    logic [3:0]                       cnt_reg;
    logic                             neg_reg;
    logic                             fix_reg;
    logic                             done_reg;
    logic [cbf_pkg::DIGIT_W-1:0]      digit;
    logic signed [cbf_pkg::W_MA+cbf_pkg::DIGIT_W:0] partial;
    logic signed [cbf_pkg::W_ACC-1:0] acc_next;

    always_comb begin
        digit    = b_reg[cbf_pkg::W_MB-1 -: cbf_pkg::DIGIT_W];
        partial  = a_reg * $signed({1'b0, digit});
        acc_next = (acc_reg <<< cbf_pkg::DIGIT_W) + cbf_pkg::W_ACC'(partial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                a_reg   <= req.a;
                b_reg   <= req.b;
                neg_reg <= req.neg;
                acc_reg <= '0;
                cnt_reg <= 4'(cbf_pkg::MUL_DIGITS);
            end else if (cnt_reg != '0) begin
                acc_reg <= acc_next;
                b_reg   <= b_reg << cbf_pkg::DIGIT_W;
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    fix_reg <= 1'b1;
                end
            end else if (fix_reg) begin
                acc_reg  <= neg_reg ? -acc_reg : acc_reg;
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule
`default_nettype wire

>>> rtl/cbf_back.sv
// back end: barrier test, projection sequencer, divider and result register
`default_nettype none
module cbf_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    input  wire cbf_pkg::item_t             q_item,
    output logic                            q_pop,
    input  wire logic [cbf_pkg::W_CFG-1:0]  safe_dist,
    input  wire logic [cbf_pkg::W_CFG-1:0]  gamma,
    output cbf_pkg::mul_req_t               mreq,
    input  wire cbf_pkg::mul_rsp_t          mrsp,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [63:0]                     m_tdata,
    output logic [1:0]                      m_tuser
);

    cbf_pkg::bk_state_t state_reg, state_next;
    cbf_pkg::step_t     step_reg, step_next;
    cbf_pkg::item_t     item_reg, item_next;
    logic signed [cbf_pkg::W_S-1:0]   t0_reg, t0_next;
    logic signed [cbf_pkg::W_S-1:0]   s_reg, s_next;
    logic signed [cbf_pkg::W_S:0]     h_reg, h_next;
    logic signed [cbf_pkg::W_MA-1:0]  b_reg, b_next;
    logic signed [cbf_pkg::W_MA-1:0]  p_reg, p_next;
    logic signed [cbf_pkg::W_MA-1:0]  num_reg, num_next;
    logic [cbf_pkg::W_ACC-1:0]        rem_reg, rem_next;
    logic [cbf_pkg::W_ACC-1:0]        dsh_reg, dsh_next;
    logic [cbf_pkg::DIV_BITS-1:0]     q_reg, q_next;
    logic [5:0]                       cnt_reg, cnt_next;
    logic signed [cbf_pkg::W_IN-1:0]  vx_reg, vx_next;
    logic signed [cbf_pkg::W_IN-1:0]  vy_reg, vy_next;
    logic                             active_reg, active_next;
    logic                             status_reg, status_next;
    logic signed [cbf_pkg::W_IN-1:0]  last_vx_reg, last_vx_next;
    logic signed [cbf_pkg::W_IN-1:0]  last_vy_reg, last_vy_next;
    logic                             m_valid_reg, m_valid_next;
    logic [63:0]                      m_data_reg, m_data_next;
    logic [1:0]                       m_user_reg, m_user_next;

    logic signed [cbf_pkg::W_MA-1:0]  op_a;
    logic signed [cbf_pkg::W_D:0]     op_b;
    logic [cbf_pkg::W_D:0]            op_mag;
    logic                             force_pos;
    logic [cbf_pkg::W_ACC-1:0]        den;
    logic                             ge;
    logic [cbf_pkg::DIV_BITS-1:0]     q_new;
    logic signed [cbf_pkg::W_SUM-1:0] qext;
    logic signed [cbf_pkg::W_SUM-1:0] uext;
    logic signed [cbf_pkg::W_SUM-1:0] sum;
    logic                             dneg;
    logic signed [cbf_pkg::W_IN-1:0]  sat_v;

    always_comb begin
        force_pos = 1'b0;
        case (step_reg)
            cbf_pkg::STEP_DXX: begin
                op_a = cbf_pkg::W_MA'(item_reg.dx);
                op_b = (cbf_pkg::W_D+1)'(item_reg.dx);
            end
            cbf_pkg::STEP_DYY: begin
                op_a = cbf_pkg::W_MA'(item_reg.dy);
                op_b = (cbf_pkg::W_D+1)'(item_reg.dy);
            end
            cbf_pkg::STEP_SAFE: begin
                op_a = cbf_pkg::W_MA'($signed({1'b0, safe_dist}));
                op_b = (cbf_pkg::W_D+1)'($signed({1'b0, safe_dist}));
            end
            cbf_pkg::STEP_GAMMA: begin
                op_a = cbf_pkg::W_MA'(h_reg);
                op_b = (cbf_pkg::W_D+1)'($signed({1'b0, gamma}));
            end
            cbf_pkg::STEP_DXU: begin
                op_a = cbf_pkg::W_MA'(item_reg.dx);
                op_b = (cbf_pkg::W_D+1)'(item_reg.ux);
            end
            cbf_pkg::STEP_DYU: begin
                op_a = cbf_pkg::W_MA'(item_reg.dy);
                op_b = (cbf_pkg::W_D+1)'(item_reg.uy);
            end
            cbf_pkg::STEP_NUMX: begin
                op_a      = num_reg;
                op_b      = (cbf_pkg::W_D+1)'(item_reg.dx);
                force_pos = 1'b1;
            end
            cbf_pkg::STEP_NUMY: begin
                op_a      = num_reg;
                op_b      = (cbf_pkg::W_D+1)'(item_reg.dy);
                force_pos = 1'b1;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        op_mag = op_b[cbf_pkg::W_D] ? (cbf_pkg::W_D+1)'(-op_b) : (cbf_pkg::W_D+1)'(op_b);
    end

    always_comb begin
        den   = cbf_pkg::W_ACC'(s_reg) << cbf_pkg::SCALE_SH;
        ge    = (rem_reg >= dsh_reg);
        q_new = {q_reg[cbf_pkg::DIV_BITS-2:0], ge};
        qext  = $signed({2'b00, q_new});
        if (step_reg == cbf_pkg::STEP_NUMX) begin
            dneg = item_reg.dx[cbf_pkg::W_D-1];
            uext = cbf_pkg::W_SUM'(item_reg.ux);
        end else begin
            dneg = item_reg.dy[cbf_pkg::W_D-1];
            uext = cbf_pkg::W_SUM'(item_reg.uy);
        end
        sum   = dneg ? (uext - qext) : (uext + qext);
        sat_v = cbf_pkg::sat32(sum);
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        item_next    = item_reg;
        t0_next      = t0_reg;
        s_next       = s_reg;
        h_next       = h_reg;
        b_next       = b_reg;
        p_next       = p_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        active_next  = active_reg;
        status_next  = status_reg;
        last_vx_next = last_vx_reg;
        last_vy_next = last_vy_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        q_pop        = 1'b0;
        mreq.start   = 1'b0;
        mreq.neg     = op_b[cbf_pkg::W_D] && !force_pos;
        mreq.a       = op_a;
        mreq.b       = cbf_pkg::W_MB'(op_mag);

        case (state_reg)
            cbf_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    step_next  = cbf_pkg::STEP_DXX;
                    state_next = cbf_pkg::BK_ISSUE;
                end
            end
            cbf_pkg::BK_ISSUE: begin
                mreq.start = 1'b1;
                state_next = cbf_pkg::BK_WAIT;
            end
            cbf_pkg::BK_WAIT: begin
                if (mrsp.done) begin
                    state_next = cbf_pkg::BK_ISSUE;
                    case (step_reg)
                        cbf_pkg::STEP_DXX: begin
                            t0_next   = cbf_pkg::W_S'(mrsp.p);
                            step_next = cbf_pkg::STEP_DYY;
                        end
                        cbf_pkg::STEP_DYY: begin
                            s_next    = t0_reg + cbf_pkg::W_S'(mrsp.p);
                            step_next = cbf_pkg::STEP_SAFE;
                        end
                        cbf_pkg::STEP_SAFE: begin
                            h_next    = (cbf_pkg::W_S+1)'(s_reg) - (cbf_pkg::W_S+1)'(mrsp.p);
                            step_next = cbf_pkg::STEP_GAMMA;
                        end
                        cbf_pkg::STEP_GAMMA: begin
                            b_next    = -cbf_pkg::W_MA'(mrsp.p);
                            step_next = cbf_pkg::STEP_DXU;
                        end
                        cbf_pkg::STEP_DXU: begin
                            t0_next   = cbf_pkg::W_S'(mrsp.p);
                            step_next = cbf_pkg::STEP_DYU;
                        end
                        cbf_pkg::STEP_DYU: begin
                            p_next     = (cbf_pkg::W_MA'(t0_reg) + cbf_pkg::W_MA'(mrsp.p))
                                         <<< cbf_pkg::SCALE_SH;
                            state_next = cbf_pkg::BK_CHECK;
                        end
                        default: begin
                            rem_next   = (cbf_pkg::W_ACC'(mrsp.p) << 1) + den;
                            dsh_next   = den << cbf_pkg::DIV_BITS;
                            q_next     = '0;
                            cnt_next   = 6'(cbf_pkg::DIV_BITS - 1);
                            state_next = cbf_pkg::BK_DIV;
                        end
                    endcase
                end
            end
            cbf_pkg::BK_CHECK: begin
                if (p_reg >= b_reg) begin
                    vx_next     = item_reg.ux;
                    vy_next     = item_reg.uy;
                    active_next = 1'b0;
                    status_next = 1'b0;
                    state_next  = cbf_pkg::BK_OUT;
                end else if (item_reg.d_zero) begin
                    vx_next     = last_vx_reg;
                    vy_next     = last_vy_reg;
                    active_next = 1'b0;
                    status_next = 1'b1;
                    state_next  = cbf_pkg::BK_OUT;
                end else begin
                    num_next   = b_reg - p_reg;
                    step_next  = cbf_pkg::STEP_NUMX;
                    state_next = cbf_pkg::BK_ISSUE;
                end
            end
            cbf_pkg::BK_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next = dsh_reg >> 1;
                q_next   = q_new;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    if (step_reg == cbf_pkg::STEP_NUMX) begin
                        vx_next    = sat_v;
                        step_next  = cbf_pkg::STEP_NUMY;
                        state_next = cbf_pkg::BK_ISSUE;
                    end else begin
                        vy_next     = sat_v;
                        active_next = 1'b1;
                        status_next = 1'b0;
                        state_next  = cbf_pkg::BK_OUT;
                    end
                end
            end
            cbf_pkg::BK_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {vy_reg, vx_reg};
                    m_user_next  = {status_reg, active_reg};
                    if (!status_reg) begin
                        last_vx_next = vx_reg;
                        last_vy_next = vy_reg;
                    end
                    state_next = cbf_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = cbf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cbf_pkg::BK_IDLE;
            step_reg    <= cbf_pkg::STEP_DXX;
            m_valid_reg <= 1'b0;
            last_vx_reg <= '0;
            last_vy_reg <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            last_vx_reg <= last_vx_next;
            last_vy_reg <= last_vy_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        t0_reg     <= t0_next;
        s_reg      <= s_next;
        h_reg      <= h_next;
        b_reg      <= b_next;
        p_reg      <= p_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        active_reg <= active_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_user_reg[0] && m_user_reg[1]))
        else $error("projected and infeasible flagged together");

    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mrsp.done |-> (state_reg == cbf_pkg::BK_WAIT))
        else $error("multiplier finished outside wait state");

    a_last_follows_solved: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cbf_pkg::BK_OUT && (!m_valid_reg || m_tready) && !status_reg)
        |=> (last_vx_reg == $past(vx_reg) && last_vy_reg == $past(vy_reg)))
        else $error("held velocity not updated after solved request");
`endif

endmodule
`default_nettype wire

>>> rtl/cbf_velocity_safety_filter.sv
// the back end handles one request at a time; six radix-16 multiplies run on the
// shared multiplier, plus two more and two 35-step radix-2 divisions for a projection
// a two-entry queue takes new requests while the back end works and the result waits
// reset (aresetn low, synchronous): registers back to 19661, held velocity to zero, queue empty
`default_nettype none
module cbf_velocity_safety_filter (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // desired_vx, desired_vy, robot_x, robot_y, obstacle_x, obstacle_y
    input  wire logic [191:0]               s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // safe_vx, safe_vy
    output logic [63:0]                     m_tdata,
    // constraint_active, status
    output logic [1:0]                      m_tuser,
    input  wire logic                       cfg_wr_en,
    input  wire logic [0:0]                 cfg_index,
    input  wire logic [cbf_pkg::W_CFG-1:0]  cfg_wdata
);

    logic [cbf_pkg::W_CFG-1:0] safe_reg;
    logic [cbf_pkg::W_CFG-1:0] safe_next;
    logic [cbf_pkg::W_CFG-1:0] gamma_reg;
    logic [cbf_pkg::W_CFG-1:0] gamma_next;
    logic                      q_full;
    logic                      q_push;
    cbf_pkg::item_t            push_item;
    logic                      q_valid;
    logic                      q_pop;
    cbf_pkg::item_t            pop_item;
    cbf_pkg::mul_req_t         mreq;
    cbf_pkg::mul_rsp_t         mrsp;

    always_comb begin
        safe_next  = safe_reg;
        gamma_next = gamma_reg;
        if (cfg_wr_en) begin
            case (cbf_pkg::cfg_idx_t'(cfg_index))
                cbf_pkg::REG_SAFE_DIST: safe_next  = cfg_wdata;
                cbf_pkg::REG_CBF_GAMMA: gamma_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            safe_reg  <= cbf_pkg::CFG_RESET;
            gamma_reg <= cbf_pkg::CFG_RESET;
        end else begin
            safe_reg  <= safe_next;
            gamma_reg <= gamma_next;
        end
    end

    cbf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    cbf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    cbf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    cbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .safe_dist (safe_reg),
        .gamma     (gamma_reg),
        .mreq      (mreq),
        .mrsp      (mrsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
